[hdl/assert_macros.svh]
// Assertion macros for the quaternion rotation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk and disabled while i_rst_n is low.
`define QVR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk and disabled while i_rst_n is low.
`define QVR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/qvr_pkg.sv]
// Package with widths, payload types and constants of the quaternion rotation block.
`default_nettype none

package qvr_pkg;

    localparam int VEC_W      = 32;
    localparam int QUAT_W     = 16;
    localparam int FRAC_SHIFT = 2 * (QUAT_W - 2);

    // Exact widths of the intermediate terms.
    localparam int PROD1_W = VEC_W + QUAT_W;
    localparam int T_W     = PROD1_W + 2;
    localparam int PROD2_W = T_W + QUAT_W;
    localparam int P_W     = PROD2_W + 2;
    localparam int R_W     = P_W - FRAC_SHIFT;

    localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(1) << (FRAC_SHIFT - 1);
    localparam logic [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W - 1){1'b1}}};
    localparam logic [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W - 1){1'b0}}};

    typedef struct packed {
        logic signed [VEC_W-1:0]  vec_x;
        logic signed [VEC_W-1:0]  vec_y;
        logic signed [VEC_W-1:0]  vec_z;
        logic signed [QUAT_W-1:0] rot_i;
        logic signed [QUAT_W-1:0] rot_j;
        logic signed [QUAT_W-1:0] rot_k;
        logic signed [QUAT_W-1:0] rot_real;
    } t_in_item;

    typedef struct packed {
        logic signed [VEC_W-1:0] world_x;
        logic signed [VEC_W-1:0] world_y;
        logic signed [VEC_W-1:0] world_z;
        logic                    clipped;
    } t_out_item;

    typedef struct packed {
        logic signed [QUAT_W-1:0] qi;
        logic signed [QUAT_W-1:0] qj;
        logic signed [QUAT_W-1:0] qk;
        logic signed [QUAT_W-1:0] qr;
    } t_quat;

    // Quaternion conj(q) * (0, v).
    typedef struct packed {
        logic signed [T_W-1:0] ti;
        logic signed [T_W-1:0] tj;
        logic signed [T_W-1:0] tk;
        logic signed [T_W-1:0] tr;
    } t_tquat;

    // Vector part of the full sandwich product.
    typedef struct packed {
        logic signed [P_W-1:0] px;
        logic signed [P_W-1:0] py;
        logic signed [P_W-1:0] pz;
    } t_pvec;

    // Handshake-side control handed to every pipeline section.
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

`default_nettype wire

[hdl/qvr_conj_mul.sv]
// First quaternion product conj(q) * (0, v): product stage and sum stage.
`default_nettype none

module qvr_conj_mul import qvr_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_stage_ctl i_ctl,
    input  wire t_in_item i_item,
    output logic          o_valid,
    output t_tquat        o_t,
    output t_quat         o_q
);

    typedef struct packed {
        logic signed [PROD1_W-1:0] rx, ry, rz;
        logic signed [PROD1_W-1:0] ix, iy, iz;
        logic signed [PROD1_W-1:0] jx, jy, jz;
        logic signed [PROD1_W-1:0] kx, ky, kz;
    } t_prod1;

    t_prod1 r_m, n_m;
    t_quat  r_q_a, r_q_b, n_q;
    t_tquat r_t, n_t;
    logic   r_va, r_vb;

    // Signed quaternion part times vector component at the full product width.
    function automatic logic signed [PROD1_W-1:0] vq_mul(input logic signed [QUAT_W-1:0] a,
                                                          input logic signed [VEC_W-1:0] b);
        return PROD1_W'(a) * PROD1_W'(b);
    endfunction

    always_comb begin
        n_q.qi = i_item.rot_i;
        n_q.qj = i_item.rot_j;
        n_q.qk = i_item.rot_k;
        n_q.qr = i_item.rot_real;

        n_m.rx = vq_mul(i_item.rot_real, i_item.vec_x);
        n_m.ry = vq_mul(i_item.rot_real, i_item.vec_y);
        n_m.rz = vq_mul(i_item.rot_real, i_item.vec_z);
        n_m.ix = vq_mul(i_item.rot_i, i_item.vec_x);
        n_m.iy = vq_mul(i_item.rot_i, i_item.vec_y);
        n_m.iz = vq_mul(i_item.rot_i, i_item.vec_z);
        n_m.jx = vq_mul(i_item.rot_j, i_item.vec_x);
        n_m.jy = vq_mul(i_item.rot_j, i_item.vec_y);
        n_m.jz = vq_mul(i_item.rot_j, i_item.vec_z);
        n_m.kx = vq_mul(i_item.rot_k, i_item.vec_x);
        n_m.ky = vq_mul(i_item.rot_k, i_item.vec_y);
        n_m.kz = vq_mul(i_item.rot_k, i_item.vec_z);
    end

    // The conjugate negates i, j and k, which folds into the signs below.
    always_comb begin
        n_t.tr = T_W'(r_m.ix) + T_W'(r_m.jy) + T_W'(r_m.kz);
        n_t.ti = T_W'(r_m.rx) - T_W'(r_m.jz) + T_W'(r_m.ky);
        n_t.tj = T_W'(r_m.ry) + T_W'(r_m.iz) - T_W'(r_m.kx);
        n_t.tk = T_W'(r_m.rz) - T_W'(r_m.iy) + T_W'(r_m.jx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_ctl.en) begin
            r_va <= i_ctl.valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_m   <= n_m;
            r_q_a <= n_q;
            r_t   <= n_t;
            r_q_b <= r_q_a;
        end
    end

    assign o_valid = r_vb;
    assign o_t     = r_t;
    assign o_q     = r_q_b;

endmodule

`default_nettype wire

[hdl/qvr_post_mul.sv]
// Second quaternion product t * q, vector part only: product stage and sum stage.
`default_nettype none

module qvr_post_mul import qvr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_stage_ctl i_ctl,
    input  wire t_tquat i_t,
    input  wire t_quat  i_q,
    output logic        o_valid,
    output t_pvec       o_p
);

    typedef struct packed {
        logic signed [PROD2_W-1:0] xa, xb, xc, xd;
        logic signed [PROD2_W-1:0] ya, yb, yc, yd;
        logic signed [PROD2_W-1:0] za, zb, zc, zd;
    } t_prod2;

    t_prod2 r_m, n_m;
    t_pvec  r_p, n_p;
    logic   r_vc, r_vd;

    // Signed intermediate part times quaternion part at the full product width.
    function automatic logic signed [PROD2_W-1:0] tq_mul(input logic signed [T_W-1:0] a,
                                                          input logic signed [QUAT_W-1:0] b);
        return PROD2_W'(a) * PROD2_W'(b);
    endfunction

    always_comb begin
        n_m.xa = tq_mul(i_t.tr, i_q.qi);
        n_m.xb = tq_mul(i_t.ti, i_q.qr);
        n_m.xc = tq_mul(i_t.tj, i_q.qk);
        n_m.xd = tq_mul(i_t.tk, i_q.qj);
        n_m.ya = tq_mul(i_t.tr, i_q.qj);
        n_m.yb = tq_mul(i_t.ti, i_q.qk);
        n_m.yc = tq_mul(i_t.tj, i_q.qr);
        n_m.yd = tq_mul(i_t.tk, i_q.qi);
        n_m.za = tq_mul(i_t.tr, i_q.qk);
        n_m.zb = tq_mul(i_t.ti, i_q.qj);
        n_m.zc = tq_mul(i_t.tj, i_q.qi);
        n_m.zd = tq_mul(i_t.tk, i_q.qr);
    end

    always_comb begin
        n_p.px = P_W'(r_m.xa) + P_W'(r_m.xb) + P_W'(r_m.xc) - P_W'(r_m.xd);
        n_p.py = P_W'(r_m.ya) - P_W'(r_m.yb) + P_W'(r_m.yc) + P_W'(r_m.yd);
        n_p.pz = P_W'(r_m.za) + P_W'(r_m.zb) - P_W'(r_m.zc) + P_W'(r_m.zd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (i_ctl.en) begin
            r_vc <= i_ctl.valid;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_m <= n_m;
            r_p <= n_p;
        end
    end

    assign o_valid = r_vd;
    assign o_p     = r_p;

endmodule

`default_nettype wire

[hdl/qvr_round_sat.sv]
// Output stage: round half up, drop the fraction bits and saturate each component.
`default_nettype none

module qvr_round_sat import qvr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_stage_ctl i_ctl,
    input  wire t_pvec i_p,
    output logic       o_valid,
    output t_out_item  o_item
);

    t_out_item r_item, n_item;
    logic      r_ve;
    logic [VEC_W:0] c_x, c_y, c_z;

    // Returns the saturation flag above the rounded component.
    function automatic logic [VEC_W:0] round_sat(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] rnd;
        logic [R_W-1:0]        sh;
        logic                  fits;
        rnd  = p + ROUND_HALF;
        sh   = rnd[P_W-1:FRAC_SHIFT];
        fits = (&sh[R_W-1:VEC_W-1]) | ~(|sh[R_W-1:VEC_W-1]);
        if (fits) begin
            return {1'b0, sh[VEC_W-1:0]};
        end else if (sh[R_W-1]) begin
            return {1'b1, VEC_MIN};
        end else begin
            return {1'b1, VEC_MAX};
        end
    endfunction

    always_comb begin
        c_x = round_sat(i_p.px);
        c_y = round_sat(i_p.py);
        c_z = round_sat(i_p.pz);
        n_item.world_x = c_x[VEC_W-1:0];
        n_item.world_y = c_y[VEC_W-1:0];
        n_item.world_z = c_z[VEC_W-1:0];
        n_item.clipped = c_x[VEC_W] | c_y[VEC_W] | c_z[VEC_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (i_ctl.en) begin
            r_ve <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_ve;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[hdl/quaternion_vector_rotate.sv]
// Throughput: one transaction per cycle unless a result waits on i_ready;
// five stages (two multiply stages, two sum stages, one round stage) all
// advance together on one enable.
// The pipeline holds whole while a result waits on i_ready.
// Reset (i_rst_n low, synchronous) empties every stage; no other state exists.
`default_nettype none
`include "assert_macros.svh"

module quaternion_vector_rotate import qvr_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);

    logic       w_en;
    logic       w_v_t, w_v_p;
    t_tquat     w_t;
    t_quat      w_q;
    t_pvec      w_p;
    t_stage_ctl w_ctl_a, w_ctl_c, w_ctl_e;
    logic       w_on_rail;

    // Every stage moves whenever the output register is empty or being taken.
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    assign w_ctl_a = '{en: w_en, valid: i_valid};
    assign w_ctl_c = '{en: w_en, valid: w_v_t};
    assign w_ctl_e = '{en: w_en, valid: w_v_p};

    qvr_conj_mul u_conj_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_a),
        .i_item  (i_data),
        .o_valid (w_v_t),
        .o_t     (w_t),
        .o_q     (w_q)
    );

    qvr_post_mul u_post_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_c),
        .i_t     (w_t),
        .i_q     (w_q),
        .o_valid (w_v_p),
        .o_p     (w_p)
    );

    qvr_round_sat u_round_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_e),
        .i_p     (w_p),
        .o_valid (o_valid),
        .o_item  (o_data)
    );

    assign w_on_rail = (o_data.world_x == VEC_MAX) || (o_data.world_x == VEC_MIN) ||
                       (o_data.world_y == VEC_MAX) || (o_data.world_y == VEC_MIN) ||
                       (o_data.world_z == VEC_MAX) || (o_data.world_z == VEC_MIN);

    `QVR_ASSERT_IMPL(a_stall_blocks_input, o_valid && !i_ready, !o_ready, "input taken during stall")
    `QVR_ASSERT_IMPL(a_empty_accepts, !o_valid, o_ready, "not ready with empty output")
    `QVR_ASSERT_IMPL(a_clip_on_rail, o_valid && o_data.clipped, w_on_rail, "clip without rail")
    `QVR_ASSERT_NEXT(a_held_result, !o_ready, o_valid, "waiting result lost")

endmodule

`default_nettype wire
